// File: rtl/rfsp_pkg.sv
// Shared types, constants and helpers of the ring FIFO with scan pointer.
package rfsp_pkg;

   localparam int SLOTS        = 16;
   localparam int ELEMENT_BITS = 32;
   localparam int POS_BITS     = $clog2(SLOTS);
   localparam int FIELD_BITS   = 32;
   localparam int CMD_BITS     = 3;

   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [ELEMENT_BITS-1:0] elem_type;
   typedef logic [FIELD_BITS-1:0]   field_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_STATUS     = 3'd0,
      CMD_PUSH       = 3'd1,
      CMD_POP        = 3'd2,
      CMD_SCAN_BEGIN = 3'd3,
      CMD_SCAN_NEXT  = 3'd4,
      CMD_SCAN_WRITE = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   // Per-transaction controls from the pointer logic to the datapath
   typedef struct packed {
      logic     wr_en;
      pos_type  wr_addr;
      elem_type wr_data;
      pos_type  rd_front;
      pos_type  rd_back;
      pos_type  rd_scan;
      logic     ok;
      logic     empty;
      logic     full;
      logic     scan_valid;
   } ctrl_type;

   // Advance a position, wrapping at the last slot
   function automatic pos_type wrap_inc(pos_type p);
      if (p == POS_BITS'(SLOTS - 1)) begin
         return '0;
      end
      return POS_BITS'(p + 1'b1);
   endfunction

   // Step a position back, wrapping at slot zero
   function automatic pos_type wrap_dec(pos_type p);
      if (p == '0) begin
         return POS_BITS'(SLOTS - 1);
      end
      return POS_BITS'(p - 1'b1);
   endfunction

   // Fit an input field to the element width
   function automatic elem_type to_elem(field_type v);
      logic [63:0] w;
      w = {32'b0, v};
      return w[ELEMENT_BITS-1:0];
   endfunction

   // Fit an element to the output field width
   function automatic field_type to_field(elem_type e);
      logic [63:0] w;
      w = 64'(e);
      return w[FIELD_BITS-1:0];
   endfunction

endpackage

// File: rtl/rfsp_if.sv
// Request and response channel interfaces of the ring FIFO with scan pointer.
interface rfsp_req_if import rfsp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [2:0]      command;
   logic [31:0]     value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface rfsp_rsp_if import rfsp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            ok;
   logic            empty_res;
   logic            full_res;
   logic [31:0]     front_value;
   logic [31:0]     back_value;
   logic            scan_valid;
   logic [31:0]     scan_value;

   modport source (output valid, output ok, output empty_res, output full_res,
                   output front_value, output back_value, output scan_valid,
                   output scan_value, input ready);
   modport sink   (input valid, input ok, input empty_res, input full_res,
                   input front_value, input back_value, input scan_valid,
                   input scan_value, output ready);
endinterface

// File: rtl/rfsp_ram.sv
// Generic RAM: one write port, one registered read port with write-through.
module rfsp_ram #(
   parameter int  DEPTH     = 16,
   parameter int  DATA_BITS = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Pass the data being written straight through to a read of the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rfsp_ctrl.sv
// Pointer registers and command decode of the ring FIFO with scan pointer.
module rfsp_ctrl import rfsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [2:0]  command,
   input  logic [31:0] value,
   output ctrl_type    ctl
);

   pos_type front_ff, front_in;
   pos_type back_ff,  back_in;
   pos_type scan_ff,  scan_in;
   logic    active_ff, active_in;

   logic    empty_now;
   logic    full_now;
   logic    scan_ok_now;
   pos_type scan_step;
   elem_type elem;

   always_comb begin
      empty_now   = (front_ff == back_ff);
      full_now    = (wrap_inc(back_ff) == front_ff);
      scan_ok_now = active_ff && !empty_now && (scan_ff != back_ff);
      scan_step   = wrap_inc(scan_ff);
      elem        = to_elem(value);

      front_in    = front_ff;
      back_in     = back_ff;
      scan_in     = scan_ff;
      active_in   = active_ff;
      ctl.wr_en   = 1'b0;
      ctl.wr_addr = back_ff;
      ctl.wr_data = elem;
      ctl.ok      = 1'b0;

      unique case (cmd_type'(command))
         CMD_STATUS: begin
            ctl.ok = 1'b1;
         end
         CMD_PUSH: begin
            if (!full_now) begin
               ctl.wr_en = 1'b1;
               back_in   = wrap_inc(back_ff);
               ctl.ok    = 1'b1;
            end
         end
         CMD_POP: begin
            if (!empty_now) begin
               front_in = wrap_inc(front_ff);
               ctl.ok   = 1'b1;
            end
         end
         CMD_SCAN_BEGIN: begin
            if (empty_now) begin
               active_in = 1'b0;
               scan_in   = '0;
            end else begin
               active_in = 1'b1;
               scan_in   = front_ff;
               ctl.ok    = 1'b1;
            end
         end
         CMD_SCAN_NEXT: begin
            if (scan_ok_now) begin
               scan_in = scan_step;
               ctl.ok  = (scan_step != back_ff);
            end
         end
         CMD_SCAN_WRITE: begin
            if (scan_ok_now) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = scan_ff;
               ctl.ok      = 1'b1;
            end
         end
         CMD_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            ctl.ok   = 1'b1;
         end
         default: begin
            ctl.ok = 1'b0;
         end
      endcase

      ctl.wr_en      = ctl.wr_en && accept;
      ctl.rd_front   = front_in;
      ctl.rd_back    = wrap_dec(back_in);
      ctl.rd_scan    = scan_in;
      ctl.empty      = (front_in == back_in);
      ctl.full       = (wrap_inc(back_in) == front_in);
      ctl.scan_valid = active_in && (front_in != back_in) && (scan_in != back_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         back_ff   <= '0;
         scan_ff   <= '0;
         active_ff <= 1'b0;
      end else if (accept) begin
         front_ff  <= front_in;
         back_ff   <= back_in;
         scan_ff   <= scan_in;
         active_ff <= active_in;
      end
   end

endmodule

// File: rtl/ring_fifo_with_scan_pointer.sv
// Top level of the ring FIFO with scan pointer.
// Ring-buffer FIFO of SLOTS entries (one always kept free) with a scan pointer
// that walks the held elements from front towards back and can overwrite them
// in place. Every request transaction carries one command and yields exactly
// one response transaction that shows ok, the empty and full flags, the front
// and back elements and the scan element as they stand after the command.
// A command is taken in every cycle that request ready is high: the pointer
// update and the element storage access both complete at the accepting clock
// edge, and the response appears in the next cycle in an output register. The
// element storage is held in three copies with one read port each (front,
// back and scan), written together; a read of an entry written by the same
// command sees the new data. Request ready stays high while the response
// register is empty or being taken in the same cycle, so responses that are
// taken at once cost no throughput; a response left waiting holds the
// request side off until it is taken. Elements read back from an entry that
// was never written are undefined; no clearing pass runs.
module ring_fifo_with_scan_pointer import rfsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rfsp_req_if.sink   req_chan,
   rfsp_rsp_if.source rsp_chan
);

   ctrl_type ctl;
   logic     accept;

   logic     rsp_valid_ff;
   logic     ok_ff;
   logic     empty_ff;
   logic     full_ff;
   logic     scan_valid_ff;

   elem_type front_rd;
   elem_type back_rd;
   elem_type scan_rd;

   // Take a new transaction whenever the response register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   rfsp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (req_chan.command),
      .value   (req_chan.value),
      .ctl     (ctl)
   );

   // One storage copy per read port; all copies take the same writes
   rfsp_ram #(.DEPTH(SLOTS), .DATA_BITS(ELEMENT_BITS)) u_ram_front (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (ctl.wr_data),
      .rd_en   (accept),
      .rd_addr (ctl.rd_front),
      .rd_data (front_rd)
   );

   rfsp_ram #(.DEPTH(SLOTS), .DATA_BITS(ELEMENT_BITS)) u_ram_back (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (ctl.wr_data),
      .rd_en   (accept),
      .rd_addr (ctl.rd_back),
      .rd_data (back_rd)
   );

   rfsp_ram #(.DEPTH(SLOTS), .DATA_BITS(ELEMENT_BITS)) u_ram_scan (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (ctl.wr_data),
      .rd_en   (accept),
      .rd_addr (ctl.rd_scan),
      .rd_data (scan_rd)
   );

   // Hold the response valid until taken; load fresh flags on every accept
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff         <= ctl.ok;
         empty_ff      <= ctl.empty;
         full_ff       <= ctl.full;
         scan_valid_ff <= ctl.scan_valid;
      end
   end

   // Drop element values to zero where the flags say there is nothing to show
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = ok_ff;
   assign rsp_chan.empty_res   = empty_ff;
   assign rsp_chan.full_res    = full_ff;
   assign rsp_chan.scan_valid  = scan_valid_ff;
   assign rsp_chan.front_value = empty_ff      ? '0 : to_field(front_rd);
   assign rsp_chan.back_value  = empty_ff      ? '0 : to_field(back_rd);
   assign rsp_chan.scan_value  = scan_valid_ff ? to_field(scan_rd) : '0;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   a_not_empty_and_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(empty_ff && full_ff))
      else $error("response flags empty and full together");

   a_scan_needs_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && scan_valid_ff) |-> !empty_ff)
      else $error("scan valid on an empty queue");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("request stalled without a waiting response");

endmodule
